// ----- design/rbe_pkg.sv -----
// Shared types, constants and helper functions of the hybrid RLE / bit-packing encoder.
package rbe_pkg;

	localparam int DATA_W              = 64;
	localparam int DATA_BYTES          = DATA_W / 8;
	localparam int BW_W                = 7;
	localparam int MIN_RUN             = 8;
	localparam int LIT_IDX_W           = $clog2(MIN_RUN);
	localparam int LIT_CNT_W           = LIT_IDX_W + 1;
	localparam int MAX_RUN_W           = 30;
	localparam int HDR_W               = MAX_RUN_W + 1;
	localparam int HDR_GROUPS          = (HDR_W + 6) / 7;
	localparam int RUN_COUNT_WIDTH_DEF = 32;
	localparam int QUEUE_DEPTH_DEF     = 4;
	localparam int PACK_HDR            = (MIN_RUN << 1) | 1;

	localparam logic [BW_W-1:0] BW_RESET = BW_W'(64);
	localparam logic [BW_W-1:0] BW_MAX   = BW_W'(DATA_W);

	localparam logic OP_ENCODE = 1'b0;
	localparam logic OP_FLUSH  = 1'b1;

	typedef enum logic [1:0] {
		KIND_HDR  = 2'd0,
		KIND_VAL  = 2'd1,
		KIND_PACK = 2'd2
	} seg_kind_t;

	typedef enum logic [1:0] {
		CMD_RLE,
		CMD_LIT,
		CMD_PACK
	} cmd_op_t;

	typedef enum logic {
		F_IDLE,
		F_WRAP
	} front_state_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_HEAD,
		B_BODY
	} back_state_t;

	// One segment for the back end: RLE run, literal group or packed group
	typedef struct packed {
		cmd_op_t               op;
		logic                  last;
		logic [MAX_RUN_W-1:0]  count;
		logic [DATA_W-1:0]     value;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

	typedef struct packed {
		logic [DATA_W-1:0] data;
		logic [3:0]        cnt;
	} hdr_t;

	function automatic logic [DATA_W-1:0] zigzag(input logic [DATA_W-1:0] v);
		return {v[DATA_W-2:0], 1'b0} ^ {DATA_W{v[DATA_W-1]}};
	endfunction

	// Keep the low n bytes, clear the rest
	function automatic logic [DATA_W-1:0] byte_mask(input logic [DATA_W-1:0] d,
		input logic [3:0] n);
		logic [DATA_W-1:0] r;
		r = '0;
		for (int b = 0; b < DATA_BYTES; b++) begin
			if (4'(b) < n) r[8*b +: 8] = d[8*b +: 8];
		end
		return r;
	endfunction

	// Unsigned LEB128, low group first, continuation flag in bit 7
	function automatic hdr_t varint(input logic [HDR_W-1:0] h);
		logic [HDR_GROUPS*7-1:0] hx;
		logic [3:0]              n;
		hdr_t                    r;
		hx = (HDR_GROUPS*7)'(h);
		n = 4'd1;
		for (int k = 1; k < HDR_GROUPS; k++) begin
			if (|(hx >> (7*k))) n = 4'(k + 1);
		end
		r.data = '0;
		for (int k = 0; k < HDR_GROUPS; k++) begin
			if (4'(k) < n) r.data[8*k +: 8] = {(4'(k + 1) < n), hx[7*k +: 7]};
		end
		r.cnt = n;
		return r;
	endfunction

endpackage

// ----- design/rbe_ifs.sv -----
// Valid/ready channel interfaces for samples, output segments and configuration.
interface rbe_in_if;
	import rbe_pkg::*;
	logic                     valid;
	logic                     ready;
	logic                     op;
	logic signed [DATA_W-1:0] value;
	modport source(output valid, op, value, input ready);
	modport sink(input valid, op, value, output ready);
endinterface

interface rbe_out_if;
	import rbe_pkg::*;
	logic              valid;
	logic              ready;
	logic [1:0]        kind;
	logic [DATA_W-1:0] data;
	logic [3:0]        byte_count;
	logic              last;
	modport source(output valid, kind, data, byte_count, last, input ready);
	modport sink(input valid, kind, data, byte_count, last, output ready);
endinterface

interface rbe_cfg_if;
	import rbe_pkg::*;
	logic            valid;
	logic            ready;
	logic [BW_W-1:0] data;
	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

// ----- design/rbe_front.sv -----
// Front end: accepts samples, tracks run and literal buffer, issues segment commands.
module rbe_front #(
	parameter int RUN_COUNT_WIDTH = rbe_pkg::RUN_COUNT_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         in_op,
	input  logic signed [rbe_pkg::DATA_W-1:0] in_value,
	output logic                         cmd_push,
	output rbe_pkg::cmd_t                cmd,
	input  rbe_pkg::q_stat_t             q_stat,
	input  logic                         buf_release,
	output logic [rbe_pkg::DATA_W-1:0]   lit_buf [rbe_pkg::MIN_RUN]
);
	import rbe_pkg::*;

	localparam int RUN_W = (RUN_COUNT_WIDTH > MAX_RUN_W) ? MAX_RUN_W : RUN_COUNT_WIDTH;

	front_state_t           state_q, state_d;
	logic [DATA_W-1:0]      prev_q, prev_d;
	logic [RUN_W-1:0]       run_q, run_d;
	logic [LIT_IDX_W-1:0]   lit_q, lit_d;
	logic                   busy_q;
	logic [DATA_W-1:0]      wrap_val_q;
	logic [LIT_IDX_W-1:0]   wrap_cnt_q;
	logic                   wrap_flush_q, wrap_flush_d;
	logic [DATA_W-1:0]      lit_buf_q [MIN_RUN];

	logic                   accept;
	logic [DATA_W-1:0]      z;
	logic                   eq, run_zero, lit_zero, run_ge_min, run_cap;
	logic [LIT_CNT_W-1:0]   fill_end;
	logic [LIT_IDX_W-1:0]   rem;
	logic                   tail;
	logic                   fill_hi, fill_lo, go_wrap, busy_set;

	assign in_ready   = (state_q == F_IDLE) && !busy_q && !q_stat.full;
	assign accept     = in_valid && in_ready;
	assign z          = zigzag(in_value);
	assign eq         = (z == prev_q);
	assign run_zero   = (run_q == '0);
	assign lit_zero   = (lit_q == '0);
	assign run_ge_min = (run_q >= RUN_W'(MIN_RUN));
	assign run_cap    = &run_q;
	// A short run is below MIN_RUN, so its low bits are the whole count
	assign fill_end   = {1'b0, lit_q} + {1'b0, run_q[LIT_IDX_W-1:0]};
	assign tail       = fill_end[LIT_IDX_W];
	assign rem        = fill_end[LIT_IDX_W-1:0];
	assign lit_buf    = lit_buf_q;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			F_IDLE: if (accept && go_wrap) state_d = F_WRAP;
			F_WRAP: if (!busy_q && !q_stat.full) state_d = F_IDLE;
			default: state_d = F_IDLE;
		endcase
	end

	// Classify the sample and pick the segment to issue
	always_comb begin
		cmd_push     = 1'b0;
		cmd.op       = CMD_RLE;
		cmd.last     = 1'b1;
		cmd.count    = MAX_RUN_W'(run_q);
		cmd.value    = prev_q;
		prev_d       = prev_q;
		run_d        = run_q;
		lit_d        = lit_q;
		fill_hi      = 1'b0;
		fill_lo      = 1'b0;
		go_wrap      = 1'b0;
		wrap_flush_d = 1'b0;
		busy_set     = 1'b0;
		unique case (state_q)
			F_IDLE: begin
				if (accept && in_op == OP_ENCODE) begin
					priority if (run_zero && lit_zero) begin
						prev_d = z;
						run_d  = RUN_W'(1);
					end else if (eq) begin
						if (run_cap) begin
							cmd_push = 1'b1;
							lit_d    = '0;
							run_d    = RUN_W'(1);
						end else begin
							run_d = run_q + RUN_W'(1);
							if (run_q == RUN_W'(MIN_RUN - 1)) begin
								lit_d = '0;
								if (!lit_zero) begin
									cmd_push  = 1'b1;
									cmd.op    = CMD_LIT;
									cmd.count = MAX_RUN_W'(lit_q);
									busy_set  = 1'b1;
								end
							end
						end
					end else begin
						prev_d = z;
						run_d  = RUN_W'(1);
						if (run_ge_min) begin
							cmd_push = 1'b1;
							lit_d    = '0;
						end else begin
							fill_hi = 1'b1;
							lit_d   = rem;
							if (tail) begin
								cmd_push = 1'b1;
								cmd.op   = CMD_PACK;
								busy_set = 1'b1;
								go_wrap  = (rem != '0);
							end
						end
					end
				end else if (accept) begin
					run_d = '0;
					lit_d = '0;
					priority if (run_ge_min) begin
						cmd_push = 1'b1;
					end else if (!run_zero) begin
						fill_hi  = 1'b1;
						cmd_push = 1'b1;
						busy_set = 1'b1;
						if (tail) begin
							cmd.op       = CMD_PACK;
							cmd.last     = (rem == '0);
							go_wrap      = (rem != '0);
							wrap_flush_d = 1'b1;
						end else begin
							cmd.op    = CMD_LIT;
							cmd.count = MAX_RUN_W'(fill_end);
						end
					end else if (!lit_zero) begin
						cmd_push  = 1'b1;
						cmd.op    = CMD_LIT;
						cmd.count = MAX_RUN_W'(lit_q);
						busy_set  = 1'b1;
					end
				end
			end
			F_WRAP: begin
				// Finish a run that spilled past a packed group, once it has drained
				if (!busy_q && !q_stat.full) begin
					fill_lo = 1'b1;
					if (wrap_flush_q) begin
						cmd_push  = 1'b1;
						cmd.op    = CMD_LIT;
						cmd.count = MAX_RUN_W'(wrap_cnt_q);
						busy_set  = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= F_IDLE;
			prev_q       <= '0;
			run_q        <= '0;
			lit_q        <= '0;
			busy_q       <= 1'b0;
			wrap_flush_q <= 1'b0;
			wrap_cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			prev_q  <= prev_d;
			run_q   <= run_d;
			lit_q   <= lit_d;
			if (busy_set) busy_q <= 1'b1;
			else if (buf_release) busy_q <= 1'b0;
			if (accept && go_wrap) begin
				wrap_flush_q <= wrap_flush_d;
				wrap_cnt_q   <= rem;
			end
		end
	end

	// Hold the spilled run value and fill the literal buffer
	always_ff @(posedge clk) begin
		if (accept && go_wrap) wrap_val_q <= prev_q;
		for (int e = 0; e < MIN_RUN; e++) begin
			if (fill_hi && LIT_IDX_W'(e) >= lit_q && LIT_CNT_W'(e) < fill_end)
				lit_buf_q[e] <= prev_q;
			else if (fill_lo && LIT_IDX_W'(e) < wrap_cnt_q)
				lit_buf_q[e] <= wrap_val_q;
		end
	end

endmodule

// ----- design/rbe_cmd_fifo.sv -----
// Short command queue between the front end and the back end.
module rbe_cmd_fifo #(
	parameter int DEPTH = rbe_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  rbe_pkg::cmd_t    wr_cmd,
	input  logic             pop,
	output rbe_pkg::cmd_t    rd_cmd,
	output rbe_pkg::q_stat_t stat
);
	import rbe_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == CNT_W'(DEPTH));
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign rd_cmd     = mem_q[rd_ptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			if (do_push && !do_pop) count_q <= count_q + CNT_W'(1);
			else if (do_pop && !do_push) count_q <= count_q - CNT_W'(1);
		end
	end

	// Store the command beat
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wr_cmd;
	end

endmodule

// ----- design/rbe_back.sv -----
// Back end: expands segment commands into header, value and bit-plane beats.
module rbe_back (
	input  logic                         clk,
	input  logic                         arst_n,
	output logic                         cmd_pop,
	input  rbe_pkg::cmd_t                cmd,
	input  rbe_pkg::q_stat_t             q_stat,
	input  logic [rbe_pkg::DATA_W-1:0]   lit_buf [rbe_pkg::MIN_RUN],
	input  logic [rbe_pkg::BW_W-1:0]     eff_w,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [1:0]                   out_kind,
	output logic [rbe_pkg::DATA_W-1:0]   out_data,
	output logic [3:0]                   out_byte_count,
	output logic                         out_last,
	output logic                         buf_release
);
	import rbe_pkg::*;

	back_state_t            state_q, state_d;
	cmd_op_t                op_q;
	logic                   last_q;
	logic [MAX_RUN_W-1:0]   cnt_q;
	logic [DATA_W-1:0]      val_q;
	logic [LIT_IDX_W-1:0]   idx_q, nlast_q, nlast_d;

	logic                   ov_q;
	seg_kind_t              okind_q;
	logic [DATA_W-1:0]      odata_q;
	logic [3:0]             ocnt_q;
	logic                   olast_q;

	logic                   load, emit, final_beat;
	logic [BW_W:0]          nb_sum;
	logic [3:0]             nb;
	logic [HDR_W-1:0]       hdr_val;
	hdr_t                   hdr;
	logic [DATA_W-1:0]      raw_val;
	logic [7:0]             plane_sel [MIN_RUN];
	logic [DATA_W-1:0]      planes;
	logic [BW_W-1:0]        pk_left;
	logic [3:0]             pk_cnt;
	seg_kind_t              beat_kind;
	logic [DATA_W-1:0]      beat_data;
	logic [3:0]             beat_cnt;

	assign nb_sum = {1'b0, eff_w} + (BW_W + 1)'(7);
	assign nb     = nb_sum[6:3];

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: if (!q_stat.empty) state_d = B_HEAD;
			B_HEAD: if (load) state_d = B_BODY;
			B_BODY: if (load && final_beat) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	// Header value of the current segment
	always_comb begin
		case (op_q)
			CMD_RLE:  hdr_val = {cnt_q, 1'b0};
			CMD_LIT:  hdr_val = {cnt_q, 1'b1};
			CMD_PACK: hdr_val = HDR_W'(PACK_HDR);
			default:  hdr_val = '0;
		endcase
		hdr = varint(hdr_val);
	end

	// Gather bit planes 8*idx .. 8*idx+7, first buffer entry in the top bit
	always_comb begin
		planes = '0;
		for (int j = 0; j < MIN_RUN; j++) begin
			plane_sel[j] = lit_buf[j][{idx_q, 3'b000} +: 8];
			for (int k = 0; k < 8; k++) planes[8*k + 7 - j] = plane_sel[j][k];
		end
		pk_left = eff_w - BW_W'({idx_q, 3'b000});
		pk_cnt  = (pk_left >= BW_W'(8)) ? 4'd8 : pk_left[3:0];
	end

	// Beat content, pop and buffer release
	always_comb begin
		load        = !ov_q || out_ready;
		cmd_pop     = (state_q == B_IDLE) && !q_stat.empty;
		emit        = (state_q != B_IDLE) && load;
		final_beat  = (state_q == B_BODY) && (idx_q == nlast_q);
		buf_release = emit && final_beat && (op_q != CMD_RLE);
		raw_val     = (op_q == CMD_RLE) ? val_q : lit_buf[idx_q];
		if (state_q == B_HEAD) begin
			beat_kind = KIND_HDR;
			beat_data = hdr.data;
			beat_cnt  = hdr.cnt;
		end else if (op_q == CMD_PACK) begin
			beat_kind = KIND_PACK;
			beat_data = byte_mask(planes, pk_cnt);
			beat_cnt  = pk_cnt;
		end else begin
			beat_kind = KIND_VAL;
			beat_data = byte_mask(raw_val, nb);
			beat_cnt  = nb;
		end
		case (cmd.op)
			CMD_LIT:  nlast_d = cmd.count[LIT_IDX_W-1:0] - LIT_IDX_W'(1);
			CMD_PACK: nlast_d = LIT_IDX_W'(nb - 4'd1);
			default:  nlast_d = '0;
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			ov_q    <= 1'b0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (emit) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
			if (cmd_pop) idx_q <= '0;
			else if (emit && state_q == B_BODY && !final_beat) idx_q <= idx_q + LIT_IDX_W'(1);
		end
	end

	// Latch the command and the output beat
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			op_q    <= cmd.op;
			last_q  <= cmd.last;
			cnt_q   <= cmd.count;
			val_q   <= cmd.value;
			nlast_q <= nlast_d;
		end
		if (emit) begin
			okind_q <= beat_kind;
			odata_q <= beat_data;
			ocnt_q  <= beat_cnt;
			olast_q <= final_beat && last_q;
		end
	end

	assign out_valid      = ov_q;
	assign out_kind       = okind_q;
	assign out_data       = odata_q;
	assign out_byte_count = ocnt_q;
	assign out_last       = olast_q;

endmodule

// ----- design/rle_bitpack_hybrid_encoder.sv -----
// Top level of the hybrid RLE / bit-packing encoder.
// Samples are zigzag mapped and classified by the front end in the cycle they are accepted.
// A sample that closes a segment pushes a command into a short queue, and the back end
// takes the command and turns it into beats, one beat per cycle into the output register
// while the output is not stalled (header, then value bytes or bit-plane groups, up to nine
// beats for a packed group). While a literal or packed segment is still being read out of
// the literal buffer, the front end holds off new samples until its final beat has loaded,
// since the next sample may overwrite the buffer; RLE segments carry their own value and do
// not hold off the input. A short run that spills past a full buffer is finished in the
// front end's wrap state after its packed group has drained. The width register may only be
// written while the block is idle; 0 acts as 1 and values above 64 as 64.
module rle_bitpack_hybrid_encoder #(
	parameter int RUN_COUNT_WIDTH = rbe_pkg::RUN_COUNT_WIDTH_DEF,
	parameter int QUEUE_DEPTH     = rbe_pkg::QUEUE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	rbe_in_if.sink    samples,
	rbe_out_if.source segments,
	rbe_cfg_if.sink   cfg
);
	import rbe_pkg::*;

	logic [BW_W-1:0]   width_q;
	logic [BW_W-1:0]   eff_w;
	logic              cmd_push, cmd_pop, buf_release;
	cmd_t              cmd_in, cmd_out;
	q_stat_t           q_stat;
	logic [DATA_W-1:0] lit_buf [MIN_RUN];

	// Hold the configured width
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) width_q <= BW_RESET;
		else if (cfg.valid) width_q <= cfg.data;
	end

	// Clamp to 1..64
	assign eff_w = (width_q == '0) ? BW_W'(1) :
	               (width_q > BW_MAX) ? BW_MAX : width_q;

	rbe_front #(
		.RUN_COUNT_WIDTH(RUN_COUNT_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (samples.valid),
		.in_ready   (samples.ready),
		.in_op      (samples.op),
		.in_value   (samples.value),
		.cmd_push   (cmd_push),
		.cmd        (cmd_in),
		.q_stat     (q_stat),
		.buf_release(buf_release),
		.lit_buf    (lit_buf)
	);

	rbe_cmd_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (cmd_push),
		.wr_cmd(cmd_in),
		.pop   (cmd_pop),
		.rd_cmd(cmd_out),
		.stat  (q_stat)
	);

	rbe_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_pop       (cmd_pop),
		.cmd           (cmd_out),
		.q_stat        (q_stat),
		.lit_buf       (lit_buf),
		.eff_w         (eff_w),
		.out_valid     (segments.valid),
		.out_ready     (segments.ready),
		.out_kind      (segments.kind),
		.out_data      (segments.data),
		.out_byte_count(segments.byte_count),
		.out_last      (segments.last),
		.buf_release   (buf_release)
	);

	// A command is never pushed into a full queue
	assert property (@(posedge clk) disable iff (!arst_n) cmd_push |-> !q_stat.full)
		else $error("command pushed into full queue");

	// The back end only takes a command that is there
	assert property (@(posedge clk) disable iff (!arst_n) cmd_pop |-> !q_stat.empty)
		else $error("command popped from empty queue");

	// A new buffer-reading segment never overlaps the release of the previous one
	assert property (@(posedge clk) disable iff (!arst_n)
		buf_release |-> !(cmd_push && cmd_in.op != CMD_RLE))
		else $error("buffer segment issued while previous one still draining");

	// Input is held off while a literal or packed segment reads the buffer
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_push && cmd_in.op != CMD_RLE) |=> !samples.ready)
		else $error("input accepted while literal buffer is being read");

endmodule

// ----- tb/rbe_segment_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the hybrid RLE / bit-packing encoder: predicts every segment beat and checks it.
module rbe_segment_checker #(
	parameter int RUN_COUNT_WIDTH = rbe_pkg::RUN_COUNT_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	rbe_in_if    samples,
	rbe_out_if   segments,
	rbe_cfg_if   cfg,
	output int   fail_count,
	output int   pending
);
	import rbe_pkg::*;

	localparam longint unsigned RUN_CAP = (RUN_COUNT_WIDTH > 30) ? 64'h3FFF_FFFF :
		((64'd1 << RUN_COUNT_WIDTH) - 64'd1);

	typedef struct {
		seg_kind_t   kind;
		logic [63:0] data;
		logic [3:0]  nbytes;
		logic        last;
	} segment_t;

	// Encoder state as the stream sees it
	logic [63:0]     run_value;
	longint unsigned run_len;
	logic [63:0]     lit_buf [MIN_RUN];
	int unsigned     lit_cnt;
	logic [6:0]      width_reg;

	segment_t burst[$];
	segment_t expected[$];

	initial begin
		fail_count = 0;
		pending    = 0;
	end

	// Effective bit width: 0 acts as 1, anything above 64 as 64
	function automatic int unsigned plane_count();
		if (width_reg == 7'd0) return 1;
		if (width_reg > 7'd64) return 64;
		return int'(width_reg);
	endfunction

	task automatic add_beat(input seg_kind_t k, input logic [63:0] d, input int unsigned n);
		segment_t s;
		s.kind   = k;
		s.data   = d;
		s.nbytes = 4'(n);
		s.last   = 1'b0;
		burst = {burst, s};
	endtask

	// LEB128 header, low group first
	task automatic add_varint(input longint unsigned h);
		logic [63:0] d;
		int unsigned k;
		d = '0;
		k = 0;
		while (h >= 128 && k < 7) begin
			d |= ((h & 64'h7F) | 64'h80) << (8 * k);
			k++;
			h >>= 7;
		end
		d |= (h & 64'hFF) << (8 * k);
		add_beat(KIND_HDR, d, k + 1);
	endtask

	task automatic add_value_bytes(input logic [63:0] v);
		int unsigned nb;
		logic [63:0] d;
		nb = (plane_count() + 7) / 8;
		d  = (nb >= 8) ? v : (v & ((64'd1 << (8 * nb)) - 64'd1));
		add_beat(KIND_VAL, d, nb);
	endtask

	task automatic close_run();
		add_varint(run_len << 1);
		add_value_bytes(run_value);
		lit_cnt = 0;
		run_len = 0;
	endtask

	task automatic drain_literals();
		if (lit_cnt == 0) return;
		add_varint((longint'(lit_cnt) << 1) | 1);
		for (int unsigned i = 0; i < lit_cnt && i < MIN_RUN; i++) add_value_bytes(lit_buf[i]);
		lit_cnt = 0;
	endtask

	// Transpose the full buffer into bit planes, up to eight plane bytes per beat
	task automatic pack_planes();
		int unsigned w;
		int unsigned k;
		logic [63:0] acc;
		logic [63:0] b;
		w   = plane_count();
		k   = 0;
		acc = '0;
		add_varint((MIN_RUN << 1) | 1);
		for (int unsigned i = 0; i < w; i++) begin
			b = '0;
			for (int j = 0; j < MIN_RUN; j++) b |= ((lit_buf[j] >> i) & 64'd1) << (7 - j);
			acc |= b << (8 * k);
			k++;
			if (k == 8 || i + 1 == w) begin
				add_beat(KIND_PACK, acc, k);
				acc = '0;
				k   = 0;
			end
		end
		lit_cnt = 0;
	endtask

	// Move a short run into the literal buffer, packing whenever it fills
	task automatic spill_run();
		for (longint unsigned i = 0; i < run_len && i < MIN_RUN; i++) begin
			lit_buf[lit_cnt % MIN_RUN] = run_value;
			lit_cnt++;
			if (lit_cnt >= MIN_RUN) pack_planes();
		end
	endtask

	task automatic predict_sample(input logic op, input logic [63:0] u);
		logic [63:0] z;
		z = (u << 1) ^ {64{u[63]}};
		burst.delete();
		if (op == OP_ENCODE) begin
			if (run_len == 0 && lit_cnt == 0) begin
				run_value = z;
				run_len   = 1;
			end else if (z == run_value) begin
				if (run_len >= RUN_CAP) begin
					close_run();
					run_value = z;
					run_len   = 1;
				end else begin
					run_len++;
					if (run_len == MIN_RUN) drain_literals();
				end
			end else begin
				if (run_len >= MIN_RUN) close_run();
				else spill_run();
				run_value = z;
				run_len   = 1;
			end
		end else begin
			if (run_len >= MIN_RUN) close_run();
			else if (run_len > 0) spill_run();
			drain_literals();
			run_len = 0;
			lit_cnt = 0;
		end
		if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
		expected = {expected, burst};
	endtask

	task automatic check_beat();
		segment_t want;
		if (expected.size() == 0) begin
			fail_count++;
			if (fail_count <= 10)
				$display("unexpected beat: kind %0d data %h bytes %0d last %0b",
					segments.kind, segments.data, segments.byte_count, segments.last);
		end else begin
			want = expected.pop_front();
			if (segments.kind !== want.kind || segments.data !== want.data ||
					segments.byte_count !== want.nbytes || segments.last !== want.last) begin
				fail_count++;
				if (fail_count <= 10)
					$display("beat mismatch: want kind %0d data %h bytes %0d last %0b,",
						want.kind, want.data, want.nbytes, want.last,
						" got kind %0d data %h bytes %0d last %0b", segments.kind,
						segments.data, segments.byte_count, segments.last);
			end
		end
	endtask

	// Sample all channels at the rising edge; retire beats before predicting new ones
	always @(posedge clk) begin
		if (!arst_n) begin
			run_value = '0;
			run_len   = 0;
			lit_cnt   = 0;
			width_reg = BW_RESET;
			expected.delete();
		end else begin
			if (cfg.valid && cfg.ready) width_reg = cfg.data;
			if (segments.valid && segments.ready) check_beat();
			if (samples.valid && samples.ready) predict_sample(samples.op, samples.value);
		end
		pending = expected.size();
	end

endmodule

// ----- tb/rle_bitpack_hybrid_encoder_tb.sv -----
`timescale 1ns / 100ps
// Stimulus and verdict for the hybrid RLE / bit-packing encoder.
module rle_bitpack_hybrid_encoder_tb;
	import rbe_pkg::*;

	localparam int RUN_BITS    = 16;
	localparam int SETTLE      = 24;
	localparam int PHASES      = 14;
	localparam int PHASE_ITEMS = 14;
	localparam int TIMEOUT_NS  = 10_000_000;

	logic clk = 1'b0;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   sent;
	logic src_calm;
	logic sink_calm;

	logic [BW_W-1:0] width_plan [12] = '{7'd0, 7'd1, 7'd3, 7'd7, 7'd8, 7'd9, 7'd16, 7'd33,
		7'd63, 7'd64, 7'd65, 7'd127};

	rbe_in_if  in_ch();
	rbe_out_if seg_ch();
	rbe_cfg_if cfg_ch();

	rle_bitpack_hybrid_encoder #(
		.RUN_COUNT_WIDTH(RUN_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.samples(in_ch),
		.segments(seg_ch),
		.cfg(cfg_ch)
	);

	rbe_segment_checker #(
		.RUN_COUNT_WIDTH(RUN_BITS)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.samples(in_ch),
		.segments(seg_ch),
		.cfg(cfg_ch),
		.fail_count(fail_count),
		.pending(pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop
	initial begin
		#(TIMEOUT_NS);
		$display("rle_bitpack_hybrid_encoder test failed");
		$finish;
	end

	// Output side: stall a random number of cycles before each beat
	initial begin
		int stall;
		seg_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = sink_calm ? 0 : $urandom_range(0, 12);
			if (stall > 0) begin
				seg_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			seg_ch.ready <= 1'b1;
			do @(posedge clk); while (!(seg_ch.valid && seg_ch.ready));
			@(negedge clk);
		end
	end

	// Offer one sample after a random gap and hold it until the beat is taken
	task automatic send_item(input logic op, input logic [63:0] v);
		int gap;
		gap = src_calm ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.op    <= op;
		in_ch.value <= v;
		do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
		sent++;
		@(negedge clk);
	endtask

	// Hold off input until every predicted beat has arrived, then let the block settle
	task automatic drain_output(input int settle);
		in_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (settle) @(negedge clk);
	endtask

	task automatic write_width(input logic [BW_W-1:0] w);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= w;
		do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Mix of small signed, full random, partial width and extreme samples
	function automatic logic [63:0] pick_sample();
		logic [63:0] r;
		int unsigned nb;
		r = {$urandom, $urandom};
		case ($urandom_range(0, 3))
			0: r = {{61{r[2]}}, r[2:0]};
			1: ;
			2: begin
				nb = $urandom_range(1, 63);
				r  = r & ((64'd1 << nb) - 64'd1);
				if ($urandom_range(0, 1) == 1) r = ~r;
			end
			default: begin
				case ($urandom_range(0, 3))
					0: r = 64'h7FFF_FFFF_FFFF_FFFF;
					1: r = 64'h8000_0000_0000_0000;
					2: r = '0;
					default: r = '1;
				endcase
			end
		endcase
		return r;
	endfunction

	// Mostly well-formed runs and literal stretches, with flushes and some noise
	task automatic random_traffic(input int budget);
		int stop;
		int sel;
		int len;
		logic [63:0] v;
		stop = sent + budget;
		while (sent < stop) begin
			sel = $urandom_range(0, 99);
			if (sel < 30) begin
				v   = pick_sample();
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(64, 66) : $urandom_range(8, 20);
				repeat (len) send_item(OP_ENCODE, v);
			end else if (sel < 55) begin
				repeat ($urandom_range(1, 4)) begin
					v = pick_sample();
					repeat ($urandom_range(1, 7)) send_item(OP_ENCODE, v);
				end
			end else if (sel < 80) begin
				repeat ($urandom_range(8, 17)) send_item(OP_ENCODE, pick_sample());
			end else if (sel < 90) begin
				send_item(OP_FLUSH, {$urandom, $urandom});
			end else if (sel < 94) begin
				drain_output(1);
			end else begin
				send_item(1'($urandom), {$urandom, $urandom});
			end
		end
	endtask

	initial begin
		logic [63:0] long_value;
		in_ch.valid  = 1'b0;
		in_ch.op     = OP_ENCODE;
		in_ch.value  = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data  = '0;
		arst_n       = 1'b0;
		sent         = 0;
		src_calm     = 1'b0;
		sink_calm    = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// Directed part at the reset width: empty flush, one RLE run, a full and a partial buffer
		send_item(OP_FLUSH, '0);
		repeat (8) send_item(OP_ENCODE, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(OP_ENCODE, 64'd5);
		send_item(OP_ENCODE, 64'h7FFF_FFFF_FFFF_FFFF);
		send_item(OP_ENCODE, 64'h8000_0000_0000_0000);
		send_item(OP_ENCODE, 64'd0);
		send_item(OP_ENCODE, 64'd1);
		send_item(OP_ENCODE, 64'hFFFF_FFFF_FFFF_FFFE);
		send_item(OP_ENCODE, 64'h0123_4567_89AB_CDEF);
		send_item(OP_ENCODE, 64'hFEDC_BA98_7654_3210);
		repeat (3) send_item(OP_ENCODE, 64'd42);
		send_item(OP_FLUSH, '1);
		send_item(OP_FLUSH, '0);

		// Random phases, one bit width each, drained before every write
		for (int p = 0; p < PHASES; p++) begin
			drain_output(SETTLE);
			write_width((p < 12) ? width_plan[p] : 7'($urandom_range(0, 127)));
			src_calm  = ($urandom_range(0, 3) == 0);
			sink_calm = ($urandom_range(0, 3) == 0);
			random_traffic(PHASE_ITEMS);
		end

		// Long run at a mid width, then break it and flush
		drain_output(SETTLE);
		write_width(7'd20);
		src_calm   = 1'b1;
		sink_calm  = 1'b0;
		long_value = {$urandom, $urandom};
		repeat (20) send_item(OP_ENCODE, long_value);
		send_item(OP_ENCODE, ~long_value);
		send_item(OP_FLUSH, '0);

		drain_output(SETTLE);
		if (fail_count == 0 && pending == 0) begin
			$display("rle_bitpack_hybrid_encoder test passed");
		end else begin
			$display("rle_bitpack_hybrid_encoder test failed");
		end
		$finish;
	end

endmodule
